FILE: hdl/sse_pkg.sv
// Shared types and defaults for the sample statistics engine.
package sse_pkg;

	localparam int SAMPLE_DEPTH_DEF = 1024;
	localparam int SAMPLE_BITS_DEF  = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_SEL,
		ST_SEL_NEXT,
		ST_MULN,
		ST_MULS,
		ST_VAR,
		ST_SQRT,
		ST_DIVM,
		ST_DIVD,
		ST_OUT
	} sse_state_t;

endpackage

FILE: hdl/sample_statistics_engine.sv
// Sample statistics engine. On an add transfer (mode 0) the sample is written to the next
// free entry of a sample memory with one write and one read port (dropped once SAMPLE_DEPTH
// entries are held) and folded into the running minimum, maximum and saturating total. A
// calculate transfer (mode 1) starts a sequencer that walks the memory, one read per cycle:
// one pass builds the sum and the sum of squares, then the median is found by bitwise rank
// selection, one pass per sample bit (SAMPLE_BITS passes for odd n, twice that for even n).
// A shift-add multiplier, a two-bits-per-cycle square root and a restoring divider used
// twice follow. With nothing stored, the sequencer goes straight to the output state and the
// result repeats the previous mean, median and deviation. No input is taken while a
// calculation runs.
module sample_statistics_engine
	import sse_pkg::*;
#(
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  mode,
	input  logic [31:0]                           sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [31:0]                           total_count,
	output logic [$clog2(SAMPLE_DEPTH+1)-1:0]     stored_count,
	output logic [39:0]                           mean_q8,
	output logic [32:0]                           median_x2,
	output logic [31:0]                           smallest,
	output logic [31:0]                           largest,
	output logic [39:0]                           deviation_q8,
	output logic                                  no_samples
);

	localparam int SW   = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
	localparam int CB   = $clog2(SAMPLE_DEPTH + 1);
	localparam int AW   = $clog2(SAMPLE_DEPTH);
	localparam int BIW  = $clog2(SW);
	localparam int SUMW = SW + CB;
	localparam int SQW  = 2 * SW + CB;
	localparam int NSQW = SQW + CB;
	localparam int VW   = NSQW + 16;
	localparam int RW   = (VW + 1) / 2;
	localparam int VWE  = 2 * RW;
	localparam int RMW  = RW + 3;
	localparam int DW   = (SUMW + 8 > RW) ? SUMW + 8 : RW;
	localparam int STW  = $clog2(DW + RW + CB + SUMW);

	sse_state_t state_q, state_d;

	logic [SW-1:0]    mem [SAMPLE_DEPTH];
	logic [SW-1:0]    rdata_s1;
	logic             rd_v_s1, v_s2;
	logic [SW-1:0]    x_s2;
	logic [2*SW-1:0]  sq_s2;

	logic [CB-1:0]    held_q;
	logic [31:0]      seen_q;
	logic [SW-1:0]    least_q, great_q;
	logic [39:0]      last_mean_q, last_dev_q;
	logic [32:0]      last_med_q;

	logic [CB-1:0]    addr_q;
	logic [STW-1:0]   step_q;
	logic [SUMW-1:0]  sum_q, mq_q;
	logic [SQW-1:0]   sumsq_q;
	logic [BIW-1:0]   bit_q;
	logic [SW-1:0]    pref_q, lo_q;
	logic [CB-1:0]    cnt_q, rank_q;
	logic             round_q;
	logic [NSQW-1:0]  vacc_q, psq_q;
	logic [VWE-1:0]   rad_q;
	logic [RMW-1:0]   rem_q;
	logic [RW-1:0]    root_q;
	logic [DW-1:0]    dq_q;
	logic [CB:0]      drem_q;

	logic             out_valid_q, no_samples_q;
	logic [31:0]      total_q, small_q, large_q;
	logic [CB-1:0]    stored_q;
	logic [39:0]      mean_q, dev_q;
	logic [32:0]      median_q;

	logic             in_fire, add_fire, issue, acc_done, sel_done, even, out_load;
	logic [SW-1:0]    s_in, lowmask, pref_new;
	logic             match, sel_one, sel_last;
	logic [RMW-1:0]   rtry, trial;
	logic             sq_ge;
	logic [CB:0]      r2;
	logic             div_ge;
	logic [DW-1:0]    q_next;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign add_fire = in_fire && !mode;
	assign s_in     = sample[SW-1:0];
	assign even     = !held_q[0];

	assign issue    = (state_q == ST_ACC || state_q == ST_SEL) && (addr_q != held_q);
	assign acc_done = (addr_q == held_q) && !rd_v_s1 && !v_s2;
	assign sel_done = (addr_q == held_q) && !rd_v_s1;

	// bits below the current one are free; the current bit must be zero and the rest must equal the prefix
	assign lowmask  = {SW{1'b1}} >> (BIW'(SW - 1) - bit_q);
	assign match    = (((rdata_s1 ^ pref_q) & ~lowmask) == '0) && !rdata_s1[bit_q];
	assign sel_one  = (rank_q >= cnt_q);
	assign pref_new = sel_one ? (pref_q | (SW'(1) << bit_q)) : pref_q;
	assign sel_last = (bit_q == '0);

	assign rtry  = {rem_q[RMW-3:0], rad_q[VWE-1 -: 2]};
	assign trial = RMW'({root_q, 2'b01});
	assign sq_ge = (rtry >= trial);

	assign r2     = {drem_q[CB-1:0], dq_q[DW-1]};
	assign div_ge = (r2 >= {1'b0, held_q});
	assign q_next = {dq_q[DW-2:0], div_ge};

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && mode) begin
					state_d = (held_q == '0) ? ST_OUT : ST_ACC;
				end
			end
			ST_ACC: begin
				if (acc_done) state_d = ST_SEL;
			end
			ST_SEL: begin
				if (sel_done) state_d = ST_SEL_NEXT;
			end
			ST_SEL_NEXT: begin
				if (sel_last && !(even && !round_q)) state_d = ST_MULN;
				else state_d = ST_SEL;
			end
			ST_MULN: begin
				if (step_q == '0) state_d = ST_MULS;
			end
			ST_MULS: begin
				if (step_q == '0) state_d = ST_VAR;
			end
			ST_VAR: state_d = ST_SQRT;
			ST_SQRT: begin
				if (step_q == '0) state_d = ST_DIVM;
			end
			ST_DIVM: begin
				if (step_q == '0) state_d = ST_DIVD;
			end
			ST_DIVD: begin
				if (step_q == '0) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sample memory
	always_ff @(posedge clk) begin
		if (add_fire && (held_q < CB'(SAMPLE_DEPTH))) begin
			mem[held_q[AW-1:0]] <= s_in;
		end
		rdata_s1 <= mem[addr_q[AW-1:0]];
	end

	// architectural state and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			seen_q      <= '0;
			least_q     <= '1;
			great_q     <= '0;
			last_mean_q <= '0;
			last_med_q  <= '0;
			last_dev_q  <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			v_s2    <= rd_v_s1 && (state_q == ST_ACC);
			if (add_fire) begin
				if (held_q < CB'(SAMPLE_DEPTH)) held_q <= held_q + 1'b1;
				if (s_in < least_q) least_q <= s_in;
				if (s_in > great_q) great_q <= s_in;
				if (seen_q != '1) seen_q <= seen_q + 1'b1;
			end
			if (state_q == ST_SEL_NEXT && sel_last && !(even && !round_q)) begin
				last_med_q <= even ? (33'(lo_q) + 33'(pref_new)) : 33'({pref_new, 1'b0});
			end
			if (state_q == ST_DIVM && step_q == '0) last_mean_q <= 40'(q_next);
			if (state_q == ST_DIVD && step_q == '0) last_dev_q  <= 40'(q_next);
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		x_s2  <= rdata_s1;
		sq_s2 <= rdata_s1 * rdata_s1;
		if (issue) addr_q <= addr_q + 1'b1;
		case (state_q)
			ST_IDLE: begin
				addr_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end
			ST_ACC: begin
				if (v_s2) begin
					sum_q   <= sum_q + SUMW'(x_s2);
					sumsq_q <= sumsq_q + SQW'(sq_s2);
				end
				if (acc_done) begin
					addr_q  <= '0;
					cnt_q   <= '0;
					pref_q  <= '0;
					bit_q   <= BIW'(SW - 1);
					round_q <= 1'b0;
					rank_q  <= even ? (held_q >> 1) - 1'b1 : (held_q >> 1);
				end
			end
			ST_SEL: begin
				if (rd_v_s1 && match) cnt_q <= cnt_q + 1'b1;
			end
			ST_SEL_NEXT: begin
				addr_q <= '0;
				cnt_q  <= '0;
				if (sel_last) begin
					// value found; for even n it is the lower middle one and a second round seeks the upper one
					lo_q    <= pref_new;
					round_q <= 1'b1;
					rank_q  <= held_q >> 1;
					pref_q  <= '0;
					bit_q   <= BIW'(SW - 1);
					vacc_q  <= '0;
					mq_q    <= SUMW'(held_q);
					step_q  <= STW'(CB - 1);
				end else begin
					pref_q <= pref_new;
					bit_q  <= bit_q - 1'b1;
					if (sel_one) rank_q <= rank_q - cnt_q;
				end
			end
			ST_MULN: begin
				vacc_q <= (vacc_q << 1) + (mq_q[CB-1] ? NSQW'(sumsq_q) : '0);
				mq_q   <= mq_q << 1;
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					psq_q  <= '0;
					mq_q   <= sum_q;
					step_q <= STW'(SUMW - 1);
				end
			end
			ST_MULS: begin
				psq_q  <= (psq_q << 1) + (mq_q[SUMW-1] ? NSQW'(sum_q) : '0);
				mq_q   <= mq_q << 1;
				step_q <= step_q - 1'b1;
			end
			ST_VAR: begin
				rad_q  <= VWE'(vacc_q - psq_q) << 16;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= STW'(RW - 1);
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= sq_ge ? rtry - trial : rtry;
				root_q <= {root_q[RW-2:0], sq_ge};
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					dq_q   <= DW'({sum_q, 8'd0});
					drem_q <= '0;
					step_q <= STW'(DW - 1);
				end
			end
			ST_DIVM, ST_DIVD: begin
				drem_q <= div_ge ? r2 - {1'b0, held_q} : r2;
				dq_q   <= q_next;
				step_q <= step_q - 1'b1;
				if (state_q == ST_DIVM && step_q == '0) begin
					dq_q   <= DW'(root_q);
					drem_q <= '0;
					step_q <= STW'(DW - 1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			total_q      <= seen_q;
			stored_q     <= held_q;
			mean_q       <= last_mean_q;
			median_q     <= last_med_q;
			small_q      <= 32'(least_q);
			large_q      <= 32'(great_q);
			dev_q        <= last_dev_q;
			no_samples_q <= (held_q == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign total_count  = total_q;
	assign stored_count = stored_q;
	assign mean_q8      = mean_q;
	assign median_x2    = median_q;
	assign smallest     = small_q;
	assign largest      = large_q;
	assign deviation_q8 = dev_q;
	assign no_samples   = no_samples_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CB'(SAMPLE_DEPTH))
		else $error("stored count beyond memory depth");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q != '0) |-> (least_q <= great_q))
		else $error("minimum above maximum");

	a_empty_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode && held_q == '0) |=> (state_q == ST_OUT))
		else $error("calculate on empty memory did not go straight to output");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC || state_q == ST_SEL) |-> (addr_q <= held_q))
		else $error("scan address ran past stored samples");

endmodule
